// ===== hw/rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
// Used by dq_front, dq_cmdq, dq_back and double_ended_queue_core.
`default_nettype none

package dq_pkg;

	// Default number of ring entries.
	localparam int DQ_DEPTH = 32;

	// Command queue between the front and back parts; a power of two.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

	// Raw command codes on the input channel.
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT = 3'd2;
	localparam logic [2:0] KIND_POP_BACK = 3'd3;
	localparam logic [2:0] KIND_LIST = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK = 3'd1,
		OP_POP_FRONT = 3'd2,
		OP_POP_BACK = 3'd3,
		OP_LIST = 3'd4
	} dq_op_t;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [31:0] value;
	} dq_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] element;
		logic last;
	} dq_out_t;

	// Classified command as it travels from the front to the back.
	typedef struct packed {
		dq_op_t op;
		logic signed [31:0] value;
	} dq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_front.sv =====
// Front part: accepts input transactions, decodes the command kind and
// drops codes without meaning. Depends on dq_pkg.
`default_nettype none

module dq_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire dq_pkg::dq_in_t  in_data,
	output logic                 fwd_valid,
	output dq_pkg::dq_cmd_t      fwd_cmd,
	input  wire logic            q_full
);

	logic            valid_s1;
	dq_pkg::dq_cmd_t cmd_s1;
	logic            accept;
	logic            known;
	dq_pkg::dq_op_t  op_dec;

	always_comb begin
		known = 1'b1;
		case (in_data.kind)
			dq_pkg::KIND_PUSH_FRONT: op_dec = dq_pkg::OP_PUSH_FRONT;
			dq_pkg::KIND_PUSH_BACK:  op_dec = dq_pkg::OP_PUSH_BACK;
			dq_pkg::KIND_POP_FRONT:  op_dec = dq_pkg::OP_POP_FRONT;
			dq_pkg::KIND_POP_BACK:   op_dec = dq_pkg::OP_POP_BACK;
			dq_pkg::KIND_LIST:       op_dec = dq_pkg::OP_LIST;
			default: begin
				op_dec = dq_pkg::OP_LIST;
				known = 1'b0;
			end
		endcase
	end

	assign in_stall = valid_s1 && q_full;
	assign accept = in_valid && !in_stall;
	assign fwd_valid = valid_s1 && !q_full;
	assign fwd_cmd = cmd_s1;

	// Unknown kinds are taken and silently discarded here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (fwd_valid) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op <= op_dec;
			cmd_s1.value <= in_data.value;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dq_cmdq.sv =====
// Short command queue that decouples the front and back parts.
// Depends on dq_pkg for its depth and the command type.
`default_nettype none

module dq_cmdq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dq_pkg::dq_cmd_t  push_cmd,
	output logic                  full,
	output logic                  valid,
	output dq_pkg::dq_cmd_t       head,
	input  wire logic             pop
);

	dq_pkg::dq_cmd_t                entries_q [dq_pkg::CMDQ_DEPTH];
	logic [dq_pkg::CMDQ_AW-1:0]     wr_ptr_q;
	logic [dq_pkg::CMDQ_AW-1:0]     rd_ptr_q;
	logic [dq_pkg::CMDQ_AW:0]       fill_q;

	assign full = fill_q == (dq_pkg::CMDQ_AW + 1)'(dq_pkg::CMDQ_DEPTH);
	assign valid = fill_q != '0;
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dq_back.sv =====
// Back part: holds the ring store and its front index and count, executes
// commands and drives the result register. Depends on dq_pkg.
`default_nettype none

module dq_back #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire dq_pkg::dq_cmd_t  q_head,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output dq_pkg::dq_out_t       res_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];

	logic [AW-1:0]      front_q;
	logic [CW-1:0]      count_q;
	logic               list_q;
	logic [AW-1:0]      rp_q;
	logic [CW-1:0]      rem_q;
	logic               rd_valid_s1;
	logic               rd_last_s1;
	logic signed [31:0] rdata_s1;
	logic               res_valid_q;
	dq_pkg::dq_out_t    res_q;

	logic               out_free;
	logic               take;
	logic               issue;
	logic               is_full;
	logic               is_empty;
	logic [AW-1:0]      front_dec;
	logic [AW-1:0]      front_inc;
	logic [AW-1:0]      rp_inc;
	logic [AW:0]        back_sum;
	logic [AW-1:0]      back_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic               res_set;
	logic [1:0]         res_status;

	assign out_free = !res_valid_q || !res_stall;
	assign take = q_valid && !list_q && !rd_valid_s1 && out_free;
	assign issue = list_q && (!rd_valid_s1 || out_free);
	assign q_pop = take;

	assign is_full = count_q == CW'(DEPTH);
	assign is_empty = count_q == '0;

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign rp_inc = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;

	// The back slot lies front + count places on; the sum stays below 2 * DEPTH.
	assign back_sum = (AW + 1)'(front_q) + (AW + 1)'(count_q);
	assign back_addr = (back_sum >= (AW + 1)'(DEPTH)) ?
		AW'(back_sum - (AW + 1)'(DEPTH)) : AW'(back_sum);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = back_addr;
		if (take && !is_full) begin
			case (q_head.op)
				dq_pkg::OP_PUSH_FRONT: begin
					mem_we = 1'b1;
					mem_waddr = front_dec;
				end
				dq_pkg::OP_PUSH_BACK: begin
					mem_we = 1'b1;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// A push, a pop or an empty list answers with one status transaction.
	always_comb begin
		res_set = 1'b0;
		res_status = dq_pkg::ST_OK;
		if (take) begin
			res_set = 1'b1;
			case (q_head.op)
				dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
					if (is_full) begin
						res_status = dq_pkg::ST_FULL;
					end
				end
				dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
					if (is_empty) begin
						res_status = dq_pkg::ST_EMPTY;
					end
				end
				dq_pkg::OP_LIST: begin
					if (is_empty) begin
						res_status = dq_pkg::ST_LIST_EMPTY;
					end else begin
						// Elements follow one per cycle from the read stage while res_stall is low.
						res_set = 1'b0;
					end
				end
				default: begin
					res_set = 1'b0;
				end
			endcase
		end
	end

	// Read data only advances on an issue, so it holds while the result stalls.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= q_head.value;
		end
		if (issue) begin
			rdata_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			list_q <= 1'b0;
			rp_q <= '0;
			rem_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (issue) begin
				rp_q <= rp_inc;
				rem_q <= rem_q - 1'b1;
				rd_valid_s1 <= 1'b1;
				rd_last_s1 <= rem_q == CW'(1);
				if (rem_q == CW'(1)) begin
					list_q <= 1'b0;
				end
			end else if (out_free) begin
				rd_valid_s1 <= 1'b0;
			end

			if (rd_valid_s1 && out_free) begin
				res_valid_q <= 1'b1;
				res_q.status <= dq_pkg::ST_OK;
				res_q.element <= rdata_s1;
				res_q.last <= rd_last_s1;
			end else if (res_set) begin
				res_valid_q <= 1'b1;
				res_q.status <= res_status;
				res_q.element <= '0;
				res_q.last <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (take) begin
				case (q_head.op)
					dq_pkg::OP_PUSH_FRONT: begin
						if (!is_full) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end
					end
					dq_pkg::OP_PUSH_BACK: begin
						if (!is_full) begin
							count_q <= count_q + 1'b1;
						end
					end
					dq_pkg::OP_POP_FRONT: begin
						if (!is_empty) begin
							front_q <= front_inc;
							count_q <= count_q - 1'b1;
						end
					end
					dq_pkg::OP_POP_BACK: begin
						if (!is_empty) begin
							count_q <= count_q - 1'b1;
						end
					end
					dq_pkg::OP_LIST: begin
						if (!is_empty) begin
							list_q <= 1'b1;
							rp_q <= front_q;
							rem_q <= count_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count exceeds ring depth");

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 && !out_free |=> rd_valid_s1 && $stable(rdata_s1))
		else $error("read stage lost an element under stall");

	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 && rd_last_s1 && out_free |=> res_valid_q && res_q.last)
		else $error("final listed element not marked last");

	a_list_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		list_q |=> $stable(count_q) && $stable(front_q))
		else $error("ring state changed during a listing");

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_core.sv =====
// Double-ended queue core: a ring store of DEPTH signed 32-bit words.
// Commands enter on cmd (push front/back, pop front/back, list all).
// Every push and pop yields one result transaction with a status and
// last set. A list yields one result per stored element, front to back,
// with last on the final one, or a single list-empty status.
// Unknown command kinds are accepted and dropped without a result.
// Results come from the result register; listed elements pass the read stage
// first, then follow one per cycle while res_stall is low. Throughput: one push
// or pop per cycle while res_stall is low; a list holds the executing part
// until its last element is read, set by the single read port of the ring
// store and its read stage. A two-entry command queue between the decoding
// part and the executing part lets commands keep arriving meanwhile.
// When res_stall is high the result register holds its transaction and
// the command queue fills, after which cmd_stall rises.
// Reset (arst_n low) empties the queue; store contents are not cleared.
// Depends on dq_pkg, dq_front, dq_cmdq and dq_back.
`default_nettype none

module double_ended_queue_core #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire dq_pkg::dq_in_t  cmd,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output dq_pkg::dq_out_t      res
);

	logic            fwd_valid;
	dq_pkg::dq_cmd_t fwd_cmd;
	logic            q_full;
	logic            q_valid;
	dq_pkg::dq_cmd_t q_head;
	logic            q_pop;

	dq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid),
		.in_stall  (cmd_stall),
		.in_data   (cmd),
		.fwd_valid (fwd_valid),
		.fwd_cmd   (fwd_cmd),
		.q_full    (q_full)
	);

	dq_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fwd_valid),
		.push_cmd (fwd_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head),
		.pop      (q_pop)
	);

	dq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res)
	);

endmodule

`default_nettype wire
